### rtl/spblit_pkg.sv
`default_nettype none
package spblit_pkg;

  localparam int unsigned STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd35;

  localparam logic [13:0] ATTR_BASE  = 14'd6144;
  localparam logic [7:0]  ATTR_VALUE = 8'h47;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic MODE_OR  = 1'b0;
  localparam logic MODE_SET = 1'b1;

  typedef struct packed {
    logic              load;
    logic              start;
    logic              issue;
    logic [STEP_W-1:0] step;
  } spblit_cmd_t;

  typedef struct packed {
    logic stage_free;
    logic draw_ok;
  } spblit_status_t;

endpackage
`default_nettype wire

### rtl/sprite_or_blit_interleaved_screen.sv
// Sprite OR-blitter for an interleaved-row bitmap screen. Pattern bytes are loaded
// one per request (kind 0) into a store of MAX_SPRITES sprites x 32 bytes; a draw
// request (kind 1) with an index below both sprite_count and MAX_SPRITES produces
// 36 write commands: 16 rows of left/right OR writes, then four 0x47 attribute
// overwrites, with last set on the final one. A draw holds the input until its
// 36 issue steps are done, one store read each through the single read port; an
// issue step waits while the output stage stalls. Writes leave at one per cycle
// while out_ready stays high, behind the reads via the registered store read and
// output register. The store is undefined until loaded; cfg_ready is always high.
`default_nettype none
module sprite_or_blit_interleaved_screen import spblit_pkg::*; #(
  parameter int unsigned MAX_SPRITES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [15:0] sprite_index,
  input  wire logic [4:0]  byte_offset,
  input  wire logic [7:0]  sprite_byte,
  input  wire logic [7:0]  x_pos,
  input  wire logic [7:0]  y_pos,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      mem_offset,
  output logic             write_mode,
  output logic [7:0]       write_data,
  output logic             last
);

  spblit_cmd_t    cmd;
  spblit_status_t status;

  assign cfg_ready = 1'b1;

  spblit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  spblit_dp #(
    .MAX_SPRITES (MAX_SPRITES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .sprite_index (sprite_index),
    .byte_offset  (byte_offset),
    .sprite_byte  (sprite_byte),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mem_offset   (mem_offset),
    .write_mode   (write_mode),
    .write_data   (write_data),
    .last         (last)
  );

endmodule
`default_nettype wire

### rtl/spblit_ctrl.sv
`default_nettype none
module spblit_ctrl import spblit_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           kind,
  input  wire spblit_status_t status,
  output spblit_cmd_t         cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              accept;

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd.load  = accept && (kind == KIND_LOAD);
  assign cmd.start = accept && (kind == KIND_DRAW) && status.draw_ok;
  assign cmd.issue = (state == RUN) && status.stage_free;
  assign cmd.step  = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      case (state)
        IDLE: begin
          step <= '0;
          if (cmd.start) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.issue) begin
            if (step == LAST_STEP) begin
              state <= IDLE;
              step  <= '0;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: begin
          state <= IDLE;
          step  <= '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/spblit_dp.sv
`default_nettype none
module spblit_dp import spblit_pkg::*; #(
  parameter int unsigned MAX_SPRITES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [6:0]  cfg_data,
  input  wire logic [15:0] sprite_index,
  input  wire logic [4:0]  byte_offset,
  input  wire logic [7:0]  sprite_byte,
  input  wire logic [7:0]  x_pos,
  input  wire logic [7:0]  y_pos,
  input  wire spblit_cmd_t cmd,
  output spblit_status_t   status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      mem_offset,
  output logic             write_mode,
  output logic [7:0]       write_data,
  output logic             last
);

  localparam int unsigned IDX_W  = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int unsigned ADDR_W = IDX_W + 5;
  localparam int unsigned DEPTH  = MAX_SPRITES * 32;

  logic [7:0]       store [DEPTH];
  logic [6:0]       sprite_count;
  logic [IDX_W-1:0] idx_q;
  logic [4:0]       xb_q;
  logic [7:0]       y_q;

  logic [7:0]  rdata;
  logic        s1_valid;
  logic [13:0] s1_offset;
  logic        s1_mode;
  logic        s1_last;

  logic              in_range;
  logic              advance;
  logic [3:0]        row;
  logic              right;
  logic [7:0]        wrow;
  logic [12:0]       row_base;
  logic [13:0]       pix_off;
  logic [5:0]        attr_row;
  logic [13:0]       attr_off;
  logic              is_attr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  assign in_range = sprite_index < 16'(MAX_SPRITES);
  assign status.draw_ok = in_range && (sprite_index < {9'b0, sprite_count});

  assign advance = !out_valid || out_ready;
  assign status.stage_free = !s1_valid || advance;

  assign is_attr  = cmd.step[5];
  assign row      = cmd.step[4:1];
  assign right    = cmd.step[0];
  assign wrow     = y_q + {4'b0, row};
  assign row_base = {wrow[7:6], wrow[2:0], wrow[5:3], 5'b0};
  assign pix_off  = {1'b0, row_base} + {9'b0, xb_q} + {13'b0, right};
  assign attr_row = {1'b0, y_q[7:3]} + {5'b0, cmd.step[1]};
  assign attr_off = ATTR_BASE + {3'b0, attr_row, 5'b0} + {9'b0, xb_q} + {13'b0, cmd.step[0]};

  assign waddr = {sprite_index[IDX_W-1:0], byte_offset};
  assign raddr = {idx_q, cmd.step[4], cmd.step[0], cmd.step[3:1]};

  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      store[waddr] <= sprite_byte;
    end
    if (cmd.issue) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_count <= '0;
    end else if (cfg_valid) begin
      sprite_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_q <= sprite_index[IDX_W-1:0];
      xb_q  <= x_pos[7:3];
      y_q   <= y_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (status.stage_free) begin
      s1_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (status.stage_free && cmd.issue) begin
      s1_offset <= is_attr ? attr_off : pix_off;
      s1_mode   <= is_attr ? MODE_SET : MODE_OR;
      s1_last   <= (cmd.step == LAST_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      mem_offset <= s1_offset;
      write_mode <= s1_mode;
      write_data <= (s1_mode == MODE_SET) ? ATTR_VALUE : rdata;
      last       <= s1_last;
    end
  end

endmodule
`default_nettype wire

### tb/sprite_or_blit_interleaved_screen_tb.sv
`default_nettype none
module sprite_or_blit_interleaved_screen_tb;
  import spblit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPRITE_SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    logic        kind;
    logic [15:0] idx;
    logic [4:0]  boff;
    logic [7:0]  pat;
    logic [7:0]  x;
    logic [7:0]  y;
  } blit_req_t;

  typedef struct packed {
    logic [13:0] offset;
    logic        mode;
    logic [7:0]  data;
    logic        last;
  } screen_write_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = 7'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [15:0] sprite_index = 16'd0;
  logic [4:0]  byte_offset = 5'd0;
  logic [7:0]  sprite_byte = 8'd0;
  logic [7:0]  x_pos = 8'd0;
  logic [7:0]  y_pos = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] mem_offset;
  logic        write_mode;
  logic [7:0]  write_data;
  logic        last;

  blit_req_t     blit_req_q[$];
  screen_write_t expected_writes[$];
  logic [7:0]    pattern_mem [SPRITE_SLOTS*32];
  logic [31:0]   loaded_mask [SPRITE_SLOTS];
  int unsigned   count_shadow = 0;
  blit_req_t     cur_req;
  screen_write_t want_wr;
  int unsigned   queued_cnt = 0;
  int unsigned   accepted_cnt = 0;
  int unsigned   send_gap = 0;
  int unsigned   hold_cnt = 0;
  int unsigned   hold_req_cnt = 0;
  int unsigned   hold_seen_cnt = 0;
  int unsigned   cycle_cnt = 0;
  int unsigned   errors = 0;
  logic          steady = 1'b0;

  sprite_or_blit_interleaved_screen #(
    .MAX_SPRITES(SPRITE_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .sprite_index(sprite_index),
    .byte_offset(byte_offset),
    .sprite_byte(sprite_byte),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mem_offset(mem_offset),
    .write_mode(write_mode),
    .write_data(write_data),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(50, 15);
  endfunction

  task automatic push_write(logic [13:0] off, logic mode, logic [7:0] data, logic lst);
    screen_write_t w;
    w.offset = off;
    w.mode = mode;
    w.data = data;
    w.last = lst;
    expected_writes.push_back(w);
  endtask

  // Compute the screen writes that one accepted request causes.
  task automatic predict_blit(blit_req_t q);
    int unsigned r, d, base, lpos;
    logic [7:0]  w;
    logic [13:0] rowb, a;
    logic [4:0]  xb;
    if (q.kind == KIND_LOAD) begin
      if (q.idx < SPRITE_SLOTS) pattern_mem[q.idx*32 + q.boff] = q.pat;
    end else if (q.idx < count_shadow && q.idx < SPRITE_SLOTS) begin
      base = q.idx * 32;
      xb = q.x[7:3];
      for (r = 0; r < 16; r++) begin
        w = q.y + 8'(r);
        rowb = {1'b0, w[7:6], w[2:0], w[5:3], 5'b0} + 14'(xb);
        lpos = (r < 8) ? r : r + 8;
        push_write(rowb, MODE_OR, pattern_mem[base + lpos], 1'b0);
        push_write(rowb + 14'd1, MODE_OR, pattern_mem[base + lpos + 8], 1'b0);
      end
      for (d = 0; d < 2; d++) begin
        a = ATTR_BASE + 14'((int'(q.y[7:3]) + d) * 32 + int'(xb));
        push_write(a, MODE_SET, ATTR_VALUE, 1'b0);
        push_write(a + 14'd1, MODE_SET, ATTR_VALUE, (d == 1) ? 1'b1 : 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_blit(cur_req);
        accepted_cnt++;
      end
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (blit_req_q.size() != 0) begin
        cur_req = blit_req_q.pop_front();
        kind <= cur_req.kind;
        sprite_index <= cur_req.idx;
        byte_offset <= cur_req.boff;
        sprite_byte <= cur_req.pat;
        x_pos <= cur_req.x;
        y_pos <= cur_req.y;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected write at mem_offset %0d", mem_offset);
          errors++;
        end else begin
          want_wr = expected_writes.pop_front();
          if (mem_offset !== want_wr.offset) begin
            $error("mem_offset: expected %0d, got %0d", want_wr.offset, mem_offset);
            errors++;
          end
          if (write_mode !== want_wr.mode) begin
            $error("write_mode: expected %0d, got %0d", want_wr.mode, write_mode);
            errors++;
          end
          if (write_data !== want_wr.data) begin
            $error("write_data: expected 0x%02h, got 0x%02h", want_wr.data, write_data);
            errors++;
          end
          if (last !== want_wr.last) begin
            $error("last: expected %0d, got %0d", want_wr.last, last);
            errors++;
          end
        end
      end
      if (hold_req_cnt != hold_seen_cnt) begin
        hold_seen_cnt <= hold_req_cnt;
        hold_cnt <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        hold_cnt <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sprite_or_blit_interleaved_screen_tb: errors");
      $finish;
    end
  end

  task automatic push_req(logic k, logic [15:0] idx, logic [4:0] boff, logic [7:0] pat,
                          logic [7:0] x, logic [7:0] y);
    blit_req_t q;
    q = {k, idx, boff, pat, x, y};
    if (k == KIND_LOAD && idx < SPRITE_SLOTS) loaded_mask[idx][boff] = 1'b1;
    blit_req_q.push_back(q);
    queued_cnt++;
  endtask

  task automatic load_sprite(int unsigned idx);
    int unsigned k;
    for (k = 0; k < 32; k++)
      push_req(KIND_LOAD, 16'(idx), 5'(k), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic draw_at(int unsigned idx, logic [7:0] x, logic [7:0] y);
    push_req(KIND_DRAW, 16'(idx), 5'($urandom_range(31)), 8'($urandom_range(255)), x, y);
  endtask

  // Draw a fully loaded sprite below the count.
  task automatic draw_loaded(int unsigned c);
    int unsigned idx;
    idx = $urandom_range(c - 1);
    if (loaded_mask[idx] != 32'hFFFF_FFFF) idx = (c == SPRITE_SLOTS) ? SPRITE_SLOTS - 1 : 0;
    draw_at(idx, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic settle();
    do @(posedge clk); while (accepted_cnt != queued_cnt || expected_writes.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_count(int unsigned v);
    @(posedge clk);
    cfg_data <= 7'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_shadow = v;
  endtask

  initial begin
    int unsigned counted, sel, idx, ph, c;
    int unsigned phase_counts[4];
    for (int i = 0; i < SPRITE_SLOTS; i++) loaded_mask[i] = 32'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_count(0);

    load_sprite(0);
    load_sprite(SPRITE_SLOTS - 1);
    push_req(KIND_LOAD, 16'd0, 5'd0, 8'hFF, 8'h00, 8'h00);
    push_req(KIND_LOAD, 16'd0, 5'd31, 8'h00, 8'hFF, 8'hFF);
    push_req(KIND_LOAD, 16'd0, 5'd8, 8'h80, 8'h00, 8'hFF);
    push_req(KIND_LOAD, 16'd0, 5'd15, 8'h01, 8'hFF, 8'h00);
    push_req(KIND_LOAD, 16'(SPRITE_SLOTS), 5'd5, 8'h5A, 8'h00, 8'h00);
    push_req(KIND_LOAD, 16'hFFFF, 5'd31, 8'hFF, 8'hFF, 8'hFF);
    draw_at(0, 8'h00, 8'h00);
    settle();

    steady = 1'b1;
    set_count(SPRITE_SLOTS);
    draw_at(0, 8'h00, 8'h00);
    draw_at(SPRITE_SLOTS - 1, 8'hFF, 8'hFF);
    draw_at(0, 8'h07, 8'hF8);
    draw_at(0, 8'h88, 8'h7F);
    draw_at(SPRITE_SLOTS, 8'h10, 8'h10);
    draw_at(16'hFFFF, 8'hFF, 8'hFF);
    push_req(KIND_LOAD, 16'd0, 5'd3, 8'hAA, 8'h00, 8'h00);
    draw_at(0, 8'hF8, 8'h01);
    settle();
    steady = 1'b0;

    set_count(1);
    draw_at(SPRITE_SLOTS - 1, 8'h40, 8'h40);
    draw_at(0, 8'($urandom_range(255)), 8'($urandom_range(255)));
    settle();

    set_count(SPRITE_SLOTS - 1);
    draw_at(SPRITE_SLOTS - 1, 8'h20, 8'h20);
    draw_at(0, 8'($urandom_range(255)), 8'($urandom_range(255)));
    settle();

    phase_counts[0] = SPRITE_SLOTS;
    phase_counts[1] = $urandom_range(SPRITE_SLOTS, 1);
    phase_counts[2] = SPRITE_SLOTS - 1;
    phase_counts[3] = $urandom_range(SPRITE_SLOTS, 32);
    for (ph = 0; ph < 4; ph++) begin
      c = phase_counts[ph];
      set_count(c);
      counted = 0;
      if (ph == 0) begin
        // hold the write side off while draws pile up behind it
        repeat (3) draw_loaded(c);
        hold_req_cnt++;
        counted = 3;
      end
      while (counted < 4) begin
        sel = $urandom_range(99);
        if (sel < 55) begin
          draw_loaded(c);
          counted++;
        end else if (sel < 80) begin
          idx = ($urandom_range(1) == 0) ? $urandom_range(SPRITE_SLOTS - 1)
                                          : $urandom_range(65535);
          push_req(KIND_LOAD, 16'(idx), 5'($urandom_range(31)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
          if (idx < SPRITE_SLOTS) counted++;
        end else begin
          idx = c + $urandom_range(65535 - c);
          draw_at(idx, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
      end
      settle();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_writes.size() == 0) begin
      $display("sprite_or_blit_interleaved_screen_tb: clean");
    end else begin
      $display("sprite_or_blit_interleaved_screen_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
